// ===== hw/rtl/sbsa_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and quotient/remainder helpers for the soft brush
// stamp accumulator. No dependencies.
package sbsa_pkg;

  localparam int CMD_W   = 2;
  localparam int POS_W   = 7;
  localparam int RDX_W   = 14;
  localparam int PIX_W   = 16;
  localparam int BRUSH_W = 9;
  localparam int RAD_W   = 8;    // radius = brush_size / 2
  localparam int RR_W    = 16;   // radius squared, also the remainder width
  localparam int QW      = 20;   // signed quotient width of the running profile terms
  localparam int NUM_W   = 26;   // divider dividend width, holds 81920 * 509
  localparam int IW      = 17;   // increment width, at most 81920
  localparam int CNT_W   = 9;    // column and row counters, up to 2r-1

  localparam logic [CMD_W-1:0] CMD_STAMP = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

  localparam logic [BRUSH_W-1:0] BRUSH_RESET = 9'd50;
  localparam logic [IW-1:0]      PIX_ONE     = 17'd32768;
  localparam int                 GAIN        = 81920;
  localparam int                 GAIN2       = 163840;

  localparam logic signed [QW-1:0] Q_ONE     = 20'sd1;
  localparam logic signed [QW-1:0] Q_ROW0    = -20'sd81920;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic [RDX_W-1:0] read_index;
  } in_t;

  typedef struct packed {
    logic             changed;
    logic [PIX_W-1:0] pixel_value;
  } out_t;

  typedef enum logic [1:0] {
    RES_NONE,
    RES_STAMP,
    RES_READ
  } res_e;

  // floor quotient and non-negative remainder of a value divided by r*r
  typedef struct packed {
    logic signed [QW-1:0] q;
    logic [RR_W-1:0]      r;
  } qr_t;

  typedef struct packed {
    logic capture;
    logic div_start;
    logic div_save;
    logic div_sel;
    logic setup;
    logic row_load;
    logic pix_step;
    logic sweep_step;
    logic rd_issue;
    logic res_load;
    res_e res_sel;
  } cmd_t;

  typedef struct packed {
    logic pos_ok;
    logic r_zero;
    logic div_done;
    logic col_last;
    logic row_last;
    logic sweep_last;
  } sts_t;

  function automatic qr_t qr_add(qr_t a, qr_t b, logic [RR_W-1:0] dv);
    qr_t         res;
    logic [RR_W:0] s;
    s     = {1'b0, a.r} + {1'b0, b.r};
    res.q = a.q + b.q;
    if (s >= {1'b0, dv}) begin
      s     = s - {1'b0, dv};
      res.q = res.q + Q_ONE;
    end
    res.r = s[RR_W-1:0];
    return res;
  endfunction

  function automatic qr_t qr_sub(qr_t a, qr_t b, logic [RR_W-1:0] dv);
    qr_t         res;
    logic [RR_W:0] s;
    s     = {1'b0, a.r} - {1'b0, b.r};
    res.q = a.q - b.q;
    if (s[RR_W]) begin
      s     = s + {1'b0, dv};
      res.q = res.q - Q_ONE;
    end
    res.r = s[RR_W-1:0];
    return res;
  endfunction

endpackage

// ===== hw/rtl/sbsa_div.sv =====
`timescale 1ns / 1ps
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on sbsa_pkg.
module sbsa_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [sbsa_pkg::NUM_W-1:0] num_i,
  input  logic [sbsa_pkg::RR_W-1:0]  den_i,
  output logic                      done_o,
  output logic [sbsa_pkg::NUM_W-1:0] quo_o,
  output logic [sbsa_pkg::RR_W-1:0]  rem_o
);
  import sbsa_pkg::*;

  localparam int CW = $clog2(NUM_W);

  logic            busy_q, done_q;
  logic [CW-1:0]   cnt_q;
  logic [NUM_W-1:0] num_q;
  logic [RR_W-1:0] rem_q, den_q;
  logic [RR_W:0]   rem_w, rem_n;
  logic            fits, last;

  assign rem_w = {rem_q, num_q[NUM_W-1]};
  assign fits  = rem_w >= {1'b0, den_q};
  assign rem_n = fits ? rem_w - {1'b0, den_q} : rem_w;
  assign last  = cnt_q == CW'(NUM_W - 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= busy_q && last;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && last) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
      cnt_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[NUM_W-2:0], fits};
      rem_q <= rem_n[RR_W-1:0];
      cnt_q <= cnt_q + CW'(1);
    end
  end

  assign done_o = done_q;
  assign quo_o  = num_q;
  assign rem_o  = rem_q;

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("divider restarted while busy");

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> rem_q < den_q)
    else $error("divider remainder not below divisor");

endmodule

// ===== hw/rtl/sbsa_dpath.sv =====
`timescale 1ns / 1ps
// Datapath: brush register, pixel memory, running profile terms, pixel
// pipeline and result register. Depends on sbsa_pkg and sbsa_div.
module sbsa_dpath #(
  parameter int GRID_SIZE = 128
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [sbsa_pkg::BRUSH_W-1:0] cfg_wdata_i,
  input  sbsa_pkg::in_t               in_data_i,
  input  sbsa_pkg::cmd_t              cmd_i,
  output sbsa_pkg::sts_t              sts_o,
  output sbsa_pkg::out_t              out_data_o
);
  import sbsa_pkg::*;

  localparam int TOTAL = GRID_SIZE * GRID_SIZE;
  localparam int AW    = $clog2(TOTAL);
  localparam int CMP_W = ((AW > RDX_W) ? AW : RDX_W) + 1;
  localparam int P_W   = $clog2(TOTAL + 384 * GRID_SIZE + 512) + 1;
  localparam logic signed [P_W-1:0] P_TOTAL  = P_W'(TOTAL);
  localparam logic signed [P_W-1:0] P_STRIDE = P_W'(GRID_SIZE);
  localparam logic signed [P_W-1:0] P_ONE    = P_W'(1);

  logic [BRUSH_W-1:0] brush_q;
  logic [RAD_W-1:0]   r_nx, r_q;
  logic [RR_W-1:0]    rr_q;
  logic [POS_W-1:0]   x_q, y_q;
  logic [AW-1:0]      rd_idx_q;
  logic               rd_ok_q;

  qr_t q1_q, c_q, arow_q, e_q, a_q, d_q, div_qr;
  logic signed [P_W-1:0] rowbase_q, p_q, x_s, y_s, r_s, row0;
  logic [CNT_W-1:0]   cnt_x_q, cnt_y_q, span_last;
  logic [AW-1:0]      sweep_q;

  logic [NUM_W-1:0]   div_num, div_quo;
  logic [RR_W-1:0]    div_rem;
  logic               div_done;

  logic               pix_ok, issue;
  logic [AW-1:0]      iss_addr;
  logic [IW-1:0]      inc;
  logic               s1_vld_q, byp_q;
  logic [AW-1:0]      s1_addr_q;
  logic [IW-1:0]      s1_inc_q, s1_sum;
  logic [PIX_W-1:0]   byp_data_q, s1_old, s1_new;

  logic [PIX_W-1:0]   mem [TOTAL];
  logic [PIX_W-1:0]   mem_rdata_q, mem_wdata;
  logic               mem_we, mem_re;
  logic [AW-1:0]      mem_waddr, mem_raddr;

  out_t               out_q;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      brush_q <= BRUSH_RESET;
    end else if (cfg_we_i) begin
      brush_q <= cfg_wdata_i;
    end
  end

  assign r_nx = brush_q[BRUSH_W-1:1];

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      r_q      <= r_nx;
      rr_q     <= RR_W'(r_nx) * RR_W'(r_nx);
      x_q      <= in_data_i.pos_x;
      y_q      <= in_data_i.pos_y;
      rd_idx_q <= AW'(in_data_i.read_index);
      rd_ok_q  <= CMP_W'(in_data_i.read_index) < CMP_W'(TOTAL);
    end
  end

  // divisions by r*r: first the row/column step seed, then the second difference
  assign span_last = {r_q, 1'b0} - CNT_W'(1);
  assign div_num   = cmd_i.div_sel ? NUM_W'(GAIN2) : NUM_W'(GAIN) * NUM_W'(span_last);

  sbsa_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (div_num),
    .den_i   (rr_q),
    .done_o  (div_done),
    .quo_o   (div_quo),
    .rem_o   (div_rem)
  );

  assign div_qr.q = signed'(div_quo[QW-1:0]);
  assign div_qr.r = div_rem;

  // first pixel of the first row: (y - r) * N + x - r
  assign x_s  = P_W'(x_q);
  assign y_s  = P_W'(y_q);
  assign r_s  = P_W'(r_q);
  assign row0 = (y_s - r_s) * P_STRIDE + x_s - r_s;

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_save) begin
      if (cmd_i.div_sel) begin
        c_q <= div_qr;
      end else begin
        q1_q <= div_qr;
      end
    end
    if (cmd_i.setup) begin
      arow_q    <= '{q: Q_ROW0, r: '0};
      e_q       <= q1_q;
      rowbase_q <= row0;
      cnt_y_q   <= '0;
    end else if (cmd_i.pix_step && sts_o.col_last) begin
      arow_q    <= qr_add(arow_q, e_q, rr_q);
      e_q       <= qr_sub(e_q, c_q, rr_q);
      rowbase_q <= rowbase_q + P_STRIDE;
      cnt_y_q   <= cnt_y_q + CNT_W'(1);
    end
    if (cmd_i.row_load) begin
      a_q     <= arow_q;
      d_q     <= q1_q;
      p_q     <= rowbase_q;
      cnt_x_q <= '0;
    end else if (cmd_i.pix_step) begin
      a_q     <= qr_add(a_q, d_q, rr_q);
      d_q     <= qr_sub(d_q, c_q, rr_q);
      p_q     <= p_q + P_ONE;
      cnt_x_q <= cnt_x_q + CNT_W'(1);
    end
  end

  // pixel pipeline: read at issue, accumulate and write in the next cycle
  assign pix_ok   = !p_q[P_W-1] && (p_q != '0) && (p_q < P_TOTAL);
  assign issue    = cmd_i.pix_step && pix_ok;
  assign iss_addr = p_q[AW-1:0];
  assign inc      = (!a_q.q[QW-1] && (a_q.q != '0)) ? a_q.q[IW-1:0] : '0;

  assign s1_old = byp_q ? byp_data_q : mem_rdata_q;
  assign s1_sum = IW'(s1_old) + s1_inc_q;
  assign s1_new = (s1_sum > PIX_ONE) ? PIX_ONE[PIX_W-1:0] : s1_sum[PIX_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      byp_q    <= 1'b0;
      sweep_q  <= '0;
    end else begin
      s1_vld_q <= issue;
      // the memory returns old data on a same-address read and write
      byp_q    <= issue && s1_vld_q && (s1_addr_q == iss_addr);
      if (cmd_i.sweep_step) begin
        sweep_q <= sts_o.sweep_last ? '0 : sweep_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      s1_addr_q  <= iss_addr;
      s1_inc_q   <= inc;
      byp_data_q <= s1_new;
    end
  end

  assign mem_we    = s1_vld_q || cmd_i.sweep_step;
  assign mem_waddr = cmd_i.sweep_step ? sweep_q : s1_addr_q;
  assign mem_wdata = cmd_i.sweep_step ? '0 : s1_new;
  assign mem_re    = issue || cmd_i.rd_issue;
  assign mem_raddr = cmd_i.rd_issue ? rd_idx_q : iss_addr;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_q <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      unique case (cmd_i.res_sel)
        RES_STAMP: out_q <= '{changed: 1'b1, pixel_value: '0};
        RES_READ:  out_q <= '{changed: 1'b0, pixel_value: rd_ok_q ? mem_rdata_q : '0};
        default:   out_q <= '0;
      endcase
    end
  end

  assign out_data_o = out_q;

  assign sts_o.pos_ok = (in_data_i.pos_x != '0) && (int'(in_data_i.pos_x) < GRID_SIZE) &&
                        (in_data_i.pos_y != '0) && (int'(in_data_i.pos_y) < GRID_SIZE);
  assign sts_o.r_zero     = r_nx == '0;
  assign sts_o.div_done   = div_done;
  assign sts_o.col_last   = cnt_x_q == span_last;
  assign sts_o.row_last   = cnt_y_q == span_last;
  assign sts_o.sweep_last = sweep_q == AW'(TOTAL - 1);

  a_one_writer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s1_vld_q && cmd_i.sweep_step))
    else $error("pixel write collides with clearing sweep");

endmodule

// ===== hw/rtl/sbsa_ctrl.sv =====
`timescale 1ns / 1ps
// Controller state machine: sequences clear sweeps, reads, divisions and the
// stamp walk, and owns the handshake flags. Depends on sbsa_pkg.
module sbsa_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic [sbsa_pkg::CMD_W-1:0] in_command_i,
  output logic                      in_stall_o,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  input  sbsa_pkg::sts_t            sts_i,
  output sbsa_pkg::cmd_t            cmd_o
);
  import sbsa_pkg::*;

  localparam logic [3:0] ST_INIT = 4'd0;
  localparam logic [3:0] ST_IDLE = 4'd1;
  localparam logic [3:0] ST_CLR  = 4'd2;
  localparam logic [3:0] ST_RDI  = 4'd3;
  localparam logic [3:0] ST_D1S  = 4'd4;
  localparam logic [3:0] ST_D1W  = 4'd5;
  localparam logic [3:0] ST_D2S  = 4'd6;
  localparam logic [3:0] ST_D2W  = 4'd7;
  localparam logic [3:0] ST_ROW  = 4'd8;
  localparam logic [3:0] ST_PIX  = 4'd9;
  localparam logic [3:0] ST_RESP = 4'd10;

  logic [3:0] state_q, state_d;
  res_e       kind_q, kind_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    kind_d      = kind_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    cmd_o.res_sel = kind_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_INIT: begin
        cmd_o.sweep_step = 1'b1;
        if (sts_i.sweep_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          unique case (in_command_i)
            CMD_STAMP: begin
              if (!sts_i.pos_ok) begin
                kind_d  = RES_NONE;
                state_d = ST_RESP;
              end else if (sts_i.r_zero) begin
                kind_d  = RES_STAMP;
                state_d = ST_RESP;
              end else begin
                kind_d  = RES_STAMP;
                state_d = ST_D1S;
              end
            end
            CMD_CLEAR: begin
              kind_d  = RES_NONE;
              state_d = ST_CLR;
            end
            CMD_READ: begin
              kind_d  = RES_READ;
              state_d = ST_RDI;
            end
            default: begin
              kind_d  = RES_NONE;
              state_d = ST_RESP;
            end
          endcase
        end
      end
      ST_CLR: begin
        cmd_o.sweep_step = 1'b1;
        if (sts_i.sweep_last) begin
          state_d = ST_RESP;
        end
      end
      ST_RDI: begin
        cmd_o.rd_issue = 1'b1;
        state_d        = ST_RESP;
      end
      ST_D1S: begin
        cmd_o.div_start = 1'b1;
        state_d         = ST_D1W;
      end
      ST_D1W: begin
        if (sts_i.div_done) begin
          cmd_o.div_save = 1'b1;
          state_d        = ST_D2S;
        end
      end
      ST_D2S: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = 1'b1;
        state_d         = ST_D2W;
      end
      ST_D2W: begin
        cmd_o.div_sel = 1'b1;
        if (sts_i.div_done) begin
          cmd_o.div_save = 1'b1;
          cmd_o.setup    = 1'b1;
          state_d        = ST_ROW;
        end
      end
      ST_ROW: begin
        cmd_o.row_load = 1'b1;
        state_d        = ST_PIX;
      end
      ST_PIX: begin
        cmd_o.pix_step = 1'b1;
        if (sts_i.col_last) begin
          state_d = sts_i.row_last ? ST_RESP : ST_ROW;
        end
      end
      ST_RESP: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.res_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      kind_q      <= RES_NONE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      kind_q      <= kind_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = state_q != ST_IDLE;
  assign out_valid_o = out_valid_q;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.res_load |-> !(out_valid_q && out_stall_i))
    else $error("result register overwritten while held");

  a_init_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_INIT && state_d != ST_INIT) |-> sts_i.sweep_last)
    else $error("left the reset sweep before the last entry");

endmodule

// ===== hw/rtl/soft_brush_stamp_accumulator.sv =====
`timescale 1ns / 1ps
// Top level of the soft brush stamp accumulator: controller plus datapath.
// Depends on sbsa_pkg, sbsa_ctrl, sbsa_dpath (and sbsa_div below it).
//
//  channel  | handshake               | payload
//  ---------+-------------------------+--------------------------------------
//  in       | in_valid_i / in_stall_o | in_data_i: command, pos, read_index
//  out      | out_valid_o/ out_stall_i| out_data_o: changed, pixel_value
//  config   | cfg_we_i                | cfg_wdata_i: brush_size
//
// One transaction in gives exactly one transaction out; items run one at a time.
// A read issues one memory read, then loads the result register; a clear writes
// zero to every pixel, one memory write per cycle. A stamp with radius
// r = brush_size/2 runs two serial divisions (26-bit dividend, one bit per cycle)
// and then walks 2r rows of 2r pixels, one read-modify-write per cycle
// through one memory read port and one write port; a rejected stamp skips both.
// After reset the memory is cleared by a sweep over all GRID_SIZE*GRID_SIZE entries
// (16384 by default) during which in_stall_o stays high; cfg writes are taken.
// The result sits in an output register, so a stalled result does not block
// the next input transaction from being accepted.
module soft_brush_stamp_accumulator #(
  parameter int GRID_SIZE = 128
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [sbsa_pkg::BRUSH_W-1:0] cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  sbsa_pkg::in_t               in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output sbsa_pkg::out_t              out_data_o
);
  import sbsa_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencing: handshake flags, state machine
  sbsa_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_command_i (in_data_i.command),
    .in_stall_o   (in_stall_o),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .sts_i        (sts),
    .cmd_o        (cmd)
  );

  // storage and arithmetic: pixel memory, brush profile terms, result register
  sbsa_dpath #(
    .GRID_SIZE (GRID_SIZE)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_data_o  (out_data_o)
  );

endmodule
